// ===== hw/rtl/pbnc_pkg.sv =====
`timescale 1ns / 1ps

package pbnc_pkg;

	// palette size and field widths
	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int IDX_W   = 8;
	localparam int RGB_W   = 24;
	localparam int MIX_W   = 16;
	localparam int DIFF_W  = 17;
	localparam int KD_W    = 23;
	localparam int PROD_W  = 2 * KD_W;
	localparam int SQ_W    = 44;
	localparam int SCORE_W = 45;

	// register defaults and mixing constants
	localparam logic [8:0]  WEIGHT_ONE       = 9'd256;
	localparam logic [8:0]  BLEND_WEIGHT_RST = 9'd128;
	localparam logic        TRUNCATE_MIX_RST = 1'b1;
	localparam logic [15:0] FRAC_MASK        = 16'hFF00;

	// channel weights of the distance
	localparam logic signed [7:0] K_RED   = 8'sd30;
	localparam logic signed [7:0] K_GREEN = 8'sd59;
	localparam logic signed [7:0] K_BLUE  = 8'sd11;

	// request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// register indexes (word address bit 2)
	localparam logic REG_BLEND_WEIGHT = 1'b0;
	localparam logic REG_TRUNCATE_MIX = 1'b1;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GET_OV,
		ST_GET_UN,
		ST_MIX,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// one channel term handed to the distance unit
	typedef struct packed {
		logic  valid;
		chan_t ch;
		logic  last_item;
	} issue_t;

	// pick one channel out of a packed rgb word
	function automatic logic [7:0] chan_of(logic [RGB_W-1:0] rgb, chan_t ch);
		logic [7:0] v;
		unique case (ch)
			CH_RED:   v = rgb[23:16];
			CH_GREEN: v = rgb[15:8];
			default:  v = rgb[7:0];
		endcase
		return v;
	endfunction

	// red, green, blue, then back to red
	function automatic chan_t next_chan(chan_t ch);
		chan_t n;
		unique case (ch)
			CH_RED:   n = CH_GREEN;
			CH_GREEN: n = CH_BLUE;
			default:  n = CH_RED;
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/pbnc_ram.sv =====
`timescale 1ns / 1ps

module pbnc_ram #(
	parameter int WIDTH = pbnc_pkg::RGB_W,
	parameter int DEPTH = pbnc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/pbnc_dist.sv =====
`timescale 1ns / 1ps

module pbnc_dist #(
	parameter int ENTRIES = pbnc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pbnc_pkg::issue_t               issue,
	input  logic [$clog2(ENTRIES)-1:0]     issue_idx,
	input  logic [pbnc_pkg::RGB_W-1:0]     entry_rgb,
	input  logic [pbnc_pkg::MIX_W-1:0]     mix_r,
	input  logic [pbnc_pkg::MIX_W-1:0]     mix_g,
	input  logic [pbnc_pkg::MIX_W-1:0]     mix_b,
	output logic                           res_valid,
	output logic [$clog2(ENTRIES)-1:0]     res_idx
);

	import pbnc_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	logic [7:0]               ent_ch;
	logic [MIX_W-1:0]         mix_sel;
	logic signed [7:0]        k_sel;
	logic signed [DIFF_W-1:0] d;
	logic signed [KD_W-1:0]   kd;
	logic signed [PROD_W-1:0] prod;
	logic [SCORE_W-1:0]       score;
	logic                     win;

	logic                     v_s1, last_s1;
	chan_t                    ch_s1;
	logic [AW-1:0]            idx_s1;
	logic signed [KD_W-1:0]   kd_s1;

	logic                     v_s2, last_s2;
	chan_t                    ch_s2;
	logic [AW-1:0]            idx_s2;
	logic [SQ_W-1:0]          sq_s2;

	logic [SCORE_W-1:0]       acc_q;
	logic [SCORE_W-1:0]       lowest_q;
	logic [AW-1:0]            best_q;
	logic                     res_valid_q;
	logic [AW-1:0]            res_idx_q;

	// channel difference in q8.8 scaled by its weight
	always_comb begin
		ent_ch = chan_of(entry_rgb, issue.ch);
		unique case (issue.ch)
			CH_RED: begin
				mix_sel = mix_r;
				k_sel   = K_RED;
			end
			CH_GREEN: begin
				mix_sel = mix_g;
				k_sel   = K_GREEN;
			end
			default: begin
				mix_sel = mix_b;
				k_sel   = K_BLUE;
			end
		endcase
		d  = $signed({1'b0, ent_ch, 8'b0}) - $signed({1'b0, mix_sel});
		kd = KD_W'(d) * KD_W'(k_sel);
	end

	// shared squarer
	assign prod = PROD_W'(kd_s1) * PROD_W'(kd_s1);

	// running sum and best compare
	assign score = acc_q + SCORE_W'(sq_s2);
	assign win   = (idx_s2 == '0) || (score < lowest_q);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= issue.valid;
			v_s2        <= v_s1;
			res_valid_q <= v_s2 && last_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		ch_s1   <= issue.ch;
		last_s1 <= issue.last_item;
		idx_s1  <= issue_idx;
		kd_s1   <= kd;
		ch_s2   <= ch_s1;
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		sq_s2   <= prod[SQ_W-1:0];
		res_idx_q <= win ? idx_s2 : best_q;
		if (v_s2) begin
			unique case (ch_s2)
				CH_RED:   acc_q <= SCORE_W'(sq_s2);
				CH_GREEN: acc_q <= score;
				default: begin
					if (win) begin
						lowest_q <= score;
						best_q   <= idx_s2;
					end
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_idx   = res_idx_q;

endmodule

// ===== hw/rtl/palette_blend_nearest_color_top.sv =====
`timescale 1ns / 1ps
// a palette load leaves busy low, so loads may arrive back to back
// a query holds busy through two palette reads, three mix steps, then one squarer pass
// per channel per entry and a 3-stage drain
// done pulses as the drain ends; a new query is taken only once the last one is through
// the receiver cannot stall; the result is shown for one cycle only
// reset: blend_weight 128, truncate_mix 1, idle; palette contents undefined until loaded

module palette_blend_nearest_color_top #(
	parameter int PALETTE_ENTRIES = pbnc_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  over_index,
	input  logic [7:0]  under_index,
	output logic        done,
	output logic [7:0]  best_index,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import pbnc_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_ENTRIES - 1);

	state_t           state_q, state_d;
	chan_t            ch_q;
	logic [AW-1:0]    idx_q;
	logic [8:0]       bw_q;
	logic             tm_q;
	logic [AW-1:0]    under_idx_q;
	logic             ov_oor_q, un_oor_q;
	logic [RGB_W-1:0] ov_q, un_q;
	logic [MIX_W-1:0] mix_r_q, mix_g_q, mix_b_q;

	logic             accept, cfg_wr;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [RGB_W-1:0] ram_rdata;
	issue_t           issue;
	logic             res_valid;
	logic [AW-1:0]    res_idx;

	logic [8:0]         w_sat;
	logic [7:0]         mix_a, mix_b;
	logic signed [8:0]  mix_diff;
	logic signed [18:0] mix_prod, mix_sum;
	logic [MIX_W-1:0]   mix_val;

	function automatic logic in_range(logic [7:0] i);
		return {1'b0, i} < 9'(PALETTE_ENTRIES);
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign ram_we = accept && (req_type == REQ_LOAD) && in_range(entry_index);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= BLEND_WEIGHT_RST;
			tm_q <= TRUNCATE_MIX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BLEND_WEIGHT: bw_q <= pwdata[8:0];
				default:          tm_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BLEND_WEIGHT: prdata = {23'b0, bw_q};
			default:          prdata = {31'b0, tm_q};
		endcase
	end

	// palette store
	pbnc_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(entry_index[AW-1:0]),
		.wdata({red, green, blue}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// one mix channel per cycle: under*256 + (over-under)*w
	always_comb begin
		w_sat    = (bw_q > WEIGHT_ONE) ? WEIGHT_ONE : bw_q;
		mix_a    = chan_of(ov_q, ch_q);
		mix_b    = chan_of(un_q, ch_q);
		mix_diff = $signed({1'b0, mix_a}) - $signed({1'b0, mix_b});
		mix_prod = 19'(mix_diff) * 19'($signed({1'b0, w_sat}));
		mix_sum  = $signed({3'b0, mix_b, 8'b0}) + mix_prod;
		mix_val  = tm_q ? (mix_sum[15:0] & FRAC_MASK) : mix_sum[15:0];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= CH_RED;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_GET_UN) begin
				ch_q  <= CH_RED;
				idx_q <= '0;
			end else if (state_q == ST_MIX) begin
				ch_q <= next_chan(ch_q);
			end else if (state_q == ST_SCAN) begin
				ch_q <= next_chan(ch_q);
				if (ch_q == CH_BLUE) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// query operands
	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_QUERY)) begin
			under_idx_q <= under_index[AW-1:0];
			ov_oor_q    <= !in_range(over_index);
			un_oor_q    <= !in_range(under_index);
		end
		if (state_q == ST_GET_OV) begin
			ov_q <= ov_oor_q ? '0 : ram_rdata;
		end
		if (state_q == ST_GET_UN) begin
			un_q <= un_oor_q ? '0 : ram_rdata;
		end
		if (state_q == ST_MIX) begin
			unique case (ch_q)
				CH_RED:   mix_r_q <= mix_val;
				CH_GREEN: mix_g_q <= mix_val;
				default:  mix_b_q <= mix_val;
			endcase
		end
	end

	// next state, palette reads and issue to the distance unit
	always_comb begin
		state_d         = state_q;
		ram_re          = 1'b0;
		ram_raddr       = idx_q;
		issue.valid     = 1'b0;
		issue.ch        = ch_q;
		issue.last_item = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_QUERY)) begin
					ram_re    = 1'b1;
					ram_raddr = over_index[AW-1:0];
					state_d   = ST_GET_OV;
				end
			end
			ST_GET_OV: begin
				ram_re    = 1'b1;
				ram_raddr = under_idx_q;
				state_d   = ST_GET_UN;
			end
			ST_GET_UN: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				state_d   = ST_MIX;
			end
			ST_MIX: begin
				if (ch_q == CH_BLUE) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue.valid     = 1'b1;
				issue.last_item = (ch_q == CH_BLUE) && (idx_q == LAST_IDX);
				if (ch_q == CH_BLUE) begin
					if (idx_q == LAST_IDX) begin
						state_d = ST_DRAIN;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				if (res_valid) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// distance unit
	pbnc_dist #(
		.ENTRIES(PALETTE_ENTRIES)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.issue_idx(idx_q),
		.entry_rgb(ram_rdata),
		.mix_r    (mix_r_q),
		.mix_g    (mix_g_q),
		.mix_b    (mix_b_q),
		.res_valid(res_valid),
		.res_idx  (res_idx)
	);

	assign done       = res_valid;
	assign best_index = 8'(res_idx);

	// checks
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_DRAIN))
		else $error("result word outside drain");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_QUERY)) |=> busy)
		else $error("query word did not raise busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_LOAD)) |=> !busy)
		else $error("load word left idle");

	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && (ch_q != CH_BLUE)) |=> $stable(idx_q))
		else $error("entry index moved inside an entry");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, best_index} < 9'(PALETTE_ENTRIES)))
		else $error("best index beyond palette");

endmodule
